@@ rtl/script_source_tokenizer_macros.svh @@
// Assertion macros shared by the tokenizer RTL.
// Used by modules that carry concurrent checks; needs clk and rst in scope.
`ifndef SCRIPT_SOURCE_TOKENIZER_MACROS_SVH
`define SCRIPT_SOURCE_TOKENIZER_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define SST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define SST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/sst_pkg.sv @@
// Shared types, token codes and character-class helpers for the tokenizer.
// Used by sst_lex_core, sst_res_fifo and script_source_tokenizer.
package sst_pkg;

  localparam int LINE_BITS   = 16;
  localparam int KW_COUNT    = 17;
  localparam int MAX_RESULTS = 4;
  localparam int FIFO_DEPTH  = 8;

  typedef logic [5:0] ttype_t;

  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_END   = 1'b1;

  localparam ttype_t TT_NUMBER  = 6'd0;
  localparam ttype_t TT_STRING  = 6'd1;
  localparam ttype_t TT_WORD    = 6'd2;
  localparam ttype_t TT_KW0     = 6'd3;
  localparam ttype_t TT_PLUS    = 6'd20;
  localparam ttype_t TT_MINUS   = 6'd22;
  localparam ttype_t TT_STAR    = 6'd24;
  localparam ttype_t TT_SLASH   = 6'd26;
  localparam ttype_t TT_SLASHEQ = 6'd27;
  localparam ttype_t TT_PERCENT = 6'd28;
  localparam ttype_t TT_ASSIGN  = 6'd29;
  localparam ttype_t TT_BANG    = 6'd31;
  localparam ttype_t TT_LESS    = 6'd33;
  localparam ttype_t TT_GREATER = 6'd35;
  localparam ttype_t TT_AND     = 6'd37;
  localparam ttype_t TT_OR      = 6'd38;
  localparam ttype_t TT_LPAREN  = 6'd39;
  localparam ttype_t TT_RPAREN  = 6'd40;
  localparam ttype_t TT_LBRACE  = 6'd41;
  localparam ttype_t TT_RBRACE  = 6'd42;
  localparam ttype_t TT_LBRACK  = 6'd43;
  localparam ttype_t TT_RBRACK  = 6'd44;
  localparam ttype_t TT_SEMI    = 6'd45;
  localparam ttype_t TT_COLON   = 6'd46;
  localparam ttype_t TT_COMMA   = 6'd47;
  localparam ttype_t TT_DOT     = 6'd48;
  localparam ttype_t TT_ERROR   = 6'd49;
  localparam ttype_t TT_END     = 6'd50;

  // Keyword spellings, right-justified: the first letter is the highest byte in use.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'("spell"), 64'("rune"), 64'("fn"), 64'("return"), 64'("if"), 64'("else"),
    64'("for"), 64'("while"), 64'("break"), 64'("continue"), 64'("true"),
    64'("false"), 64'("null"), 64'("let"), 64'("vec3"), 64'("fail"), 64'("log")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd4, 4'd2, 4'd6, 4'd2, 4'd4, 4'd3, 4'd5, 4'd5, 4'd8, 4'd4, 4'd5, 4'd4,
    4'd3, 4'd4, 4'd4, 4'd3
  };

  typedef struct packed {
    logic                 kind;
    ttype_t               ttype;
    logic [7:0]           value;
    logic [LINE_BITS-1:0] line;
    logic                 last;
  } res_t;

  // Everything one input transfer produces, handed to the result queue.
  typedef struct packed {
    logic [2:0]                   count;
    res_t [MAX_RESULTS-1:0]       items;
  } bundle_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_wordc(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_");
  endfunction

  // Keywords whose letter at position p equals c.
  function automatic logic [KW_COUNT-1:0] kw_keep(logic [7:0] c, logic [3:0] p);
    logic [KW_COUNT-1:0] m;
    logic [3:0]          sh;
    m = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      sh = 4'd0;
      if (p < KW_LEN[k]) begin
        sh = KW_LEN[k] - 4'd1 - p;
        m[k] = (KW_TEXT[k][{sh[2:0], 3'b000} +: 8] == c);
      end
    end
    return m;
  endfunction

  // First surviving keyword of the exact length, else a plain identifier.
  function automatic ttype_t word_type(logic [KW_COUNT-1:0] cand, logic [3:0] len);
    ttype_t t;
    t = TT_WORD;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand[k] && (KW_LEN[k] == len)) t = 6'(int'(TT_KW0) + k);
    end
    return t;
  endfunction

  function automatic ttype_t op_base(logic [7:0] p);
    ttype_t t;
    case (p)
      "+": t = TT_PLUS;
      "-": t = TT_MINUS;
      "*": t = TT_STAR;
      "=": t = TT_ASSIGN;
      "!": t = TT_BANG;
      "<": t = TT_LESS;
      default: t = TT_GREATER;
    endcase
    return t;
  endfunction

  function automatic res_t mk(logic kind, ttype_t ttype, logic [7:0] value);
    res_t r;
    r = '0;
    r.kind  = kind;
    r.ttype = ttype;
    r.value = value;
    return r;
  endfunction

endpackage

@@ rtl/sst_lex_core.sv @@
// Lexer state registers and the single-pass next-state and result logic.
// Depends on sst_pkg.
module sst_lex_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           char_code,
  input  logic                 end_of_source,
  output sst_pkg::bundle_t     bundle
);

  typedef enum logic [3:0] {
    M_IDLE, M_NUMBER, M_NUMDOT, M_STRING, M_WORD, M_LINECMT, M_BLOCKCMT, M_SLASH, M_OP
  } mode_t;

  localparam logic [sst_pkg::LINE_BITS-1:0] LINE_MAX = '1;

  mode_t                              mode, mode_next;
  logic [7:0]                         pend, pend_next;
  logic [sst_pkg::KW_COUNT-1:0]       cand, cand_next;
  logic [3:0]                         wlen, wlen_next;
  logic [sst_pkg::LINE_BITS-1:0]      line_count, line_count_next;
  logic                               esc, esc_next;
  logic                               star, star_next;
  logic                               frac, frac_next;

  logic                               consumed;
  logic [2:0]                         n;
  sst_pkg::res_t [sst_pkg::MAX_RESULTS-1:0] res;
  logic [7:0]                         c;

  assign c = char_code;

  always_comb begin
    mode_next = mode;
    pend_next = pend;
    cand_next = cand;
    wlen_next = wlen;
    line_count_next = line_count;
    esc_next = esc;
    star_next = star;
    frac_next = frac;
    consumed = 1'b1;
    n = 3'd0;
    res = '0;

    if (end_of_source) begin
      // Close whatever token is open, then the end token, then back to reset.
      case (mode)
        M_NUMBER: begin
          res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_NUMBER, 8'd0); n = n + 3'd1;
        end
        M_NUMDOT: begin
          res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_NUMBER, 8'd0); n = n + 3'd1;
          res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_DOT, 8'd0); n = n + 3'd1;
        end
        M_STRING: begin
          res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_STRING, 8'd0); n = n + 3'd1;
        end
        M_WORD: begin
          res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::word_type(cand, wlen), 8'd0);
          n = n + 3'd1;
        end
        M_SLASH: begin
          res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_SLASH, 8'd0); n = n + 3'd1;
        end
        M_OP: begin
          if (pend != "&" && pend != "|") begin
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::op_base(pend), 8'd0);
            n = n + 3'd1;
          end
        end
        default: ;
      endcase
      res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_END, 8'd0); n = n + 3'd1;
      mode_next = M_IDLE;
      pend_next = 8'd0;
      cand_next = '1;
      wlen_next = 4'd0;
      line_count_next = {{(sst_pkg::LINE_BITS-1){1'b0}}, 1'b1};
      esc_next = 1'b0;
      star_next = 1'b0;
      frac_next = 1'b0;
    end else begin
      // First pass: the open token sees the byte; it may hand it back.
      case (mode)
        M_IDLE: consumed = 1'b0;
        M_NUMBER: begin
          if (sst_pkg::is_digit(c)) begin
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_VALUE, sst_pkg::TT_NUMBER, c); n = n + 3'd1;
          end else if (c == "." && !frac) begin
            mode_next = M_NUMDOT;
          end else begin
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_NUMBER, 8'd0); n = n + 3'd1;
            mode_next = M_IDLE;
            consumed = 1'b0;
          end
        end
        M_NUMDOT: begin
          if (sst_pkg::is_digit(c)) begin
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_VALUE, sst_pkg::TT_NUMBER, "."); n = n + 3'd1;
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_VALUE, sst_pkg::TT_NUMBER, c); n = n + 3'd1;
            frac_next = 1'b1;
            mode_next = M_NUMBER;
          end else begin
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_NUMBER, 8'd0); n = n + 3'd1;
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_DOT, 8'd0); n = n + 3'd1;
            mode_next = M_IDLE;
            consumed = 1'b0;
          end
        end
        M_STRING: begin
          if (esc) begin
            esc_next = 1'b0;
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_VALUE, sst_pkg::TT_STRING,
                                      (c == "n") ? "\n" : (c == "t") ? "\t" : c);
            n = n + 3'd1;
          end else if (c == "\\") begin
            esc_next = 1'b1;
          end else if (c == "\"") begin
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_STRING, 8'd0); n = n + 3'd1;
            mode_next = M_IDLE;
          end else begin
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_VALUE, sst_pkg::TT_STRING, c); n = n + 3'd1;
          end
        end
        M_WORD: begin
          if (sst_pkg::is_wordc(c)) begin
            cand_next = cand & sst_pkg::kw_keep(c, wlen);
            wlen_next = (wlen == 4'd15) ? wlen : wlen + 4'd1;
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_VALUE, sst_pkg::TT_WORD, c); n = n + 3'd1;
          end else begin
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::word_type(cand, wlen), 8'd0);
            n = n + 3'd1;
            mode_next = M_IDLE;
            consumed = 1'b0;
          end
        end
        M_LINECMT: begin
          if (c == "\n") begin
            mode_next = M_IDLE;
            consumed = 1'b0;
          end
        end
        M_BLOCKCMT: begin
          if (star && c == "/") begin
            star_next = 1'b0;
            mode_next = M_IDLE;
          end else begin
            star_next = (c == "*");
          end
        end
        M_SLASH: begin
          if (c == "/") begin
            mode_next = M_LINECMT;
          end else if (c == "*") begin
            mode_next = M_BLOCKCMT;
            star_next = 1'b0;
          end else begin
            mode_next = M_IDLE;
            if (c == "=") begin
              res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_SLASHEQ, 8'd0);
              n = n + 3'd1;
            end else begin
              res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_SLASH, 8'd0);
              n = n + 3'd1;
              consumed = 1'b0;
            end
          end
        end
        M_OP: begin
          mode_next = M_IDLE;
          if (pend == "&" || pend == "|") begin
            if (c == pend) begin
              res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END,
                                        (pend == "&") ? sst_pkg::TT_AND : sst_pkg::TT_OR, 8'd0);
              n = n + 3'd1;
            end else begin
              consumed = 1'b0;
            end
          end else if (c == "=") begin
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::op_base(pend) + 6'd1, 8'd0);
            n = n + 3'd1;
          end else begin
            res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::op_base(pend), 8'd0);
            n = n + 3'd1;
            consumed = 1'b0;
          end
        end
        default: begin
          mode_next = M_IDLE;
          consumed = 1'b0;
        end
      endcase

      // Second pass: a byte handed back is lexed from idle, which always takes it.
      if (!consumed) begin
        case (c)
          " ", "\t", "\r", "\n": ;
          "\"": begin
            mode_next = M_STRING;
            esc_next = 1'b0;
          end
          "/": mode_next = M_SLASH;
          "+", "-", "*", "=", "!", "<", ">", "&", "|": begin
            mode_next = M_OP;
            pend_next = c;
          end
          "%": begin res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_PERCENT, 8'd0); n = n + 3'd1; end
          "(": begin res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_LPAREN, 8'd0); n = n + 3'd1; end
          ")": begin res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_RPAREN, 8'd0); n = n + 3'd1; end
          "{": begin res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_LBRACE, 8'd0); n = n + 3'd1; end
          "}": begin res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_RBRACE, 8'd0); n = n + 3'd1; end
          "[": begin res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_LBRACK, 8'd0); n = n + 3'd1; end
          "]": begin res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_RBRACK, 8'd0); n = n + 3'd1; end
          ";": begin res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_SEMI, 8'd0); n = n + 3'd1; end
          ":": begin res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_COLON, 8'd0); n = n + 3'd1; end
          ",": begin res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_COMMA, 8'd0); n = n + 3'd1; end
          ".": begin res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_DOT, 8'd0); n = n + 3'd1; end
          default: begin
            if (sst_pkg::is_digit(c)) begin
              mode_next = M_NUMBER;
              frac_next = 1'b0;
              res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_VALUE, sst_pkg::TT_NUMBER, c); n = n + 3'd1;
            end else if (sst_pkg::is_alpha(c) || c == "_") begin
              mode_next = M_WORD;
              cand_next = sst_pkg::kw_keep(c, 4'd0);
              wlen_next = 4'd1;
              res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_VALUE, sst_pkg::TT_WORD, c); n = n + 3'd1;
            end else begin
              res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_VALUE, sst_pkg::TT_ERROR, c); n = n + 3'd1;
              res[n[1:0]] = sst_pkg::mk(sst_pkg::KIND_END, sst_pkg::TT_ERROR, 8'd0); n = n + 3'd1;
            end
          end
        endcase
      end

      if (c == "\n" && line_count != LINE_MAX) line_count_next = line_count + 1'b1;
    end

    // All results of one byte carry the line count from before that byte.
    for (int i = 0; i < sst_pkg::MAX_RESULTS; i++) res[i].line = line_count;
    if (n != 3'd0) res[n[1:0] - 2'd1].last = 1'b1;
  end

  assign bundle.count = n;
  assign bundle.items = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pend <= 8'd0;
      cand <= '1;
      wlen <= 4'd0;
      line_count <= {{(sst_pkg::LINE_BITS-1){1'b0}}, 1'b1};
      esc <= 1'b0;
      star <= 1'b0;
      frac <= 1'b0;
    end else if (take) begin
      mode <= mode_next;
      pend <= pend_next;
      cand <= cand_next;
      wlen <= wlen_next;
      line_count <= line_count_next;
      esc <= esc_next;
      star <= star_next;
      frac <= frac_next;
    end
  end

endmodule

@@ rtl/sst_res_fifo.sv @@
// Result queue: takes up to four results per cycle while room is high, hands out one per transfer.
// Depends on sst_pkg and the assertion macro header.
`include "script_source_tokenizer_macros.svh"

module sst_res_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sst_pkg::bundle_t bundle,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output sst_pkg::res_t    head
);

  localparam int DEPTH = sst_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sst_pkg::res_t     mem [DEPTH];
  logic [PTR_W-1:0]  wptr, rptr;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  push_n;
  logic              pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= CNT_W'(DEPTH - sst_pkg::MAX_RESULTS));
  assign push_n    = push ? CNT_W'(bundle.count) : '0;
  assign count_next = count + push_n - CNT_W'(pop);
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push_n);
      rptr  <= rptr + PTR_W'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sst_pkg::MAX_RESULTS; i++) begin
      if (push && (i < int'(bundle.count))) mem[PTR_W'(int'(wptr) + i)] <= bundle.items[i];
    end
  end

  `SST_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "result queue count beyond depth")
  `SST_ASSERT(a_push_fits, push |-> (count + push_n <= CNT_W'(DEPTH)), "result queue overflow")
  `SST_ASSERT(a_push_shows, (push && bundle.count != 3'd0) |=> out_valid, "pushed result not visible")

endmodule

@@ rtl/script_source_tokenizer.sv @@
// Top level of the streaming source tokenizer.
// Depends on sst_pkg, sst_lex_core and sst_res_fifo.
//
// The tokenizer takes one source byte (or an end marker) per input transfer and
// turns it into zero to four results: token value bytes as they are consumed,
// and a token-end result that carries the token type and the line number. The
// lexer state and all per-byte work sit in one pass of logic in front of an
// eight-entry result queue, so a byte is accepted in every cycle while the queue
// has at least four free entries. The output side moves one result per transfer,
// so sustained throughput is one byte per cycle as long as bytes average at most
// one result each, and the input stalls only while the queue holds more than four
// results, after multi-result bursts or while out_ready is low. Results carry
// last_result on the final result caused by a byte. The end marker closes any
// open token, emits the end token and returns the lexer to its reset state.
module script_source_tokenizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      char_code,
  input  logic                            end_of_source,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            result_kind,
  output logic [5:0]                      token_type,
  output logic [7:0]                      value_char,
  output logic [sst_pkg::LINE_BITS-1:0]   line_number,
  output logic                            last_result
);

  sst_pkg::bundle_t bundle;
  sst_pkg::res_t    head;
  logic             take;

  // An input transfer updates the lexer state and queues its results together.
  assign take = in_valid && in_ready;

  sst_lex_core u_core (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .char_code     (char_code),
    .end_of_source (end_of_source),
    .bundle        (bundle)
  );

  sst_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .bundle    (bundle),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign result_kind = head.kind;
  assign token_type  = head.ttype;
  assign value_char  = head.value;
  assign line_number = head.line;
  assign last_result = head.last;

endmodule
